FILE: hw/rtl/bfpm_pkg.sv
// ----------------------------------------------------------------------------
// bfpm_pkg: battery fault persistence monitor package
// Shared constants, codes and payload types.
// ----------------------------------------------------------------------------
package bfpm_pkg;

  localparam int NUM_CELLS     = 6;
  localparam int TEMP_CHECK    = 1;
  localparam int BATTERY_CHECK = 1;

  localparam int CELL_GROUP = 6;
  localparam int NCOND      = 2 * CELL_GROUP + 3;
  localparam int COND_W     = 4;
  localparam int TIMER_W    = 16;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COND_W-1:0] COND_TEMP = COND_W'(2 * CELL_GROUP);
  localparam logic [COND_W-1:0] COND_CURR = COND_W'(2 * CELL_GROUP + 1);
  localparam logic [COND_W-1:0] COND_BATT = COND_W'(2 * CELL_GROUP + 2);

  // request codes
  localparam logic [1:0] REQ_EVAL    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_ENABLE  = 2'd2;
  localparam logic [1:0] REQ_DISABLE = 2'd3;

  // relay event codes
  localparam logic [1:0] RELAY_NONE    = 2'd0;
  localparam logic [1:0] RELAY_ENABLE  = 2'd1;
  localparam logic [1:0] RELAY_DISABLE = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELL_MIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_MAX     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_MAX     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_MAX  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BATT_LEVEL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CELL_TIMEOUT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PACK_TIMEOUT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_COND_MASK    = 3'd7;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        cell_voltage_0;
    logic [15:0]        cell_voltage_1;
    logic [15:0]        cell_voltage_2;
    logic [15:0]        cell_voltage_3;
    logic [15:0]        cell_voltage_4;
    logic [15:0]        cell_voltage_5;
    logic signed [15:0] pack_temperature;
    logic signed [15:0] pack_current;
    logic               battery_present;
  } in_beat_t;

  typedef struct packed {
    logic              error_active;
    logic              output_enabled;
    logic              cause_valid;
    logic [COND_W-1:0] cause_id;
    logic [COND_W-1:0] trip_cause;
    logic [1:0]        relay_event;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        cell_min_mv;
    logic [15:0]        cell_max_mv;
    logic signed [15:0] temp_max;
    logic signed [15:0] current_max;
    logic               battery_error_level;
    logic [TIMER_W-1:0] cell_timeout_ms;
    logic [TIMER_W-1:0] pack_timeout_ms;
    logic [NCOND-1:0]   condition_enable_mask;
  } cfg_regs_t;

  // per-cycle command to every timer cell
  typedef struct packed {
    logic eval;
    logic tick;
    logic reload;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/bfpm_if.sv
// ----------------------------------------------------------------------------
// bfpm_if: channel interfaces
// Input beat, result beat and register write channels.
// ----------------------------------------------------------------------------
interface bfpm_in_if;
  import bfpm_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfpm_out_if;
  import bfpm_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfpm_cfg_if;
  import bfpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bfpm_cond.sv
// ----------------------------------------------------------------------------
// bfpm_cond: condition compare
// Flags every enabled condition that is failing for the current beat.
// ----------------------------------------------------------------------------
module bfpm_cond (
  input  bfpm_pkg::in_beat_t         beat,
  input  bfpm_pkg::cfg_regs_t        cfg,
  input  logic                       out_enabled,
  output logic [bfpm_pkg::NCOND-1:0] fail
);
  import bfpm_pkg::*;

  logic [CELL_GROUP-1:0][15:0] volt;
  logic [NCOND-1:0]            bad;

  assign volt = {beat.cell_voltage_5, beat.cell_voltage_4, beat.cell_voltage_3,
                 beat.cell_voltage_2, beat.cell_voltage_1, beat.cell_voltage_0};

  always_comb begin
    bad = '0;
    for (int c = 0; c < CELL_GROUP; c++) begin
      if (c < NUM_CELLS) begin
        bad[c]              = volt[c] < cfg.cell_min_mv;
        bad[c + CELL_GROUP] = volt[c] > cfg.cell_max_mv;
      end
    end
    bad[COND_TEMP] = (TEMP_CHECK != 0) && (beat.pack_temperature > cfg.temp_max);
    bad[COND_CURR] = beat.pack_current > cfg.current_max;
    // presence only counts while the output is on
    bad[COND_BATT] = (BATTERY_CHECK != 0) && out_enabled &&
                     (beat.battery_present == cfg.battery_error_level);
  end

  assign fail = bad & cfg.condition_enable_mask;

endmodule

FILE: hw/rtl/bfpm_cell.sv
// ----------------------------------------------------------------------------
// bfpm_cell: persistence timer cell
// One countdown timer plus one link of the lowest-index priority chain.
// ----------------------------------------------------------------------------
module bfpm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  bfpm_pkg::cell_ctrl_t         ctrl,
  input  logic                         fail,
  input  logic [bfpm_pkg::TIMER_W-1:0] timeout,
  input  logic                         hit_in,
  output logic                         hit_out,
  output logic                         first
);
  import bfpm_pkg::*;

  logic [TIMER_W-1:0] count, count_next;
  logic               running, running_next;
  logic               expired;

  // expiry looks at the count before this beat's update
  assign expired = fail && (count == '0);
  assign hit_out = hit_in | expired;
  assign first   = expired & ~hit_in;

  always_comb begin
    count_next   = count;
    running_next = running;
    priority if (ctrl.reload) begin
      count_next   = timeout;
      running_next = 1'b0;
    end else if (ctrl.eval) begin
      if (fail) begin
        running_next = 1'b1;
      end else begin
        count_next   = timeout;
        running_next = 1'b0;
      end
    end else if (ctrl.tick) begin
      if (running && count != '0) begin
        count_next = count - TIMER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      running <= 1'b0;
    end else begin
      count   <= count_next;
      running <= running_next;
    end
  end

endmodule

FILE: hw/rtl/battery_fault_persistence_monitor_top.sv
// Each accepted input beat's result beat is registered and offered in the following cycle.
// Throughput: one beat per cycle; input ready drops only while a result
// waits in the output register and the sink is not taking it.
// Every timer cell updates in the cycle its beat is accepted.
// Reset (rst, synchronous): registers at their defaults, timers stopped at
// zero, no cause, output disabled, monitor off. No clearing pass.
// ----------------------------------------------------------------------------
// battery_fault_persistence_monitor_top: battery protection fault monitor
// Chain of 15 persistence timer cells with lowest-index cause pick, trip
// handling, register file and a registered result stage.
// ----------------------------------------------------------------------------
module battery_fault_persistence_monitor_top (
  input logic        clk,
  input logic        rst,
  bfpm_in_if.sink    in_ch,
  bfpm_out_if.source out_ch,
  bfpm_cfg_if.sink   cfg_ch
);
  import bfpm_pkg::*;

  // --------------------------------------------------------------------------
  // Register file. Writes always accepted; every index maps to a register.
  // --------------------------------------------------------------------------
  cfg_regs_t cfg;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_min_mv           <= 16'd3000;
      cfg.cell_max_mv           <= 16'd4200;
      cfg.temp_max              <= 16'sd600;
      cfg.current_max           <= 16'sd5000;
      cfg.battery_error_level   <= 1'b0;
      cfg.cell_timeout_ms       <= TIMER_W'(1000);
      cfg.pack_timeout_ms       <= TIMER_W'(1000);
      cfg.condition_enable_mask <= '1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CELL_MIN:     cfg.cell_min_mv           <= cfg_ch.data;
        REG_CELL_MAX:     cfg.cell_max_mv           <= cfg_ch.data;
        REG_TEMP_MAX:     cfg.temp_max              <= cfg_ch.data;
        REG_CURRENT_MAX:  cfg.current_max           <= cfg_ch.data;
        REG_BATT_LEVEL:   cfg.battery_error_level   <= cfg_ch.data[0];
        REG_CELL_TIMEOUT: cfg.cell_timeout_ms       <= cfg_ch.data[TIMER_W-1:0];
        REG_PACK_TIMEOUT: cfg.pack_timeout_ms       <= cfg_ch.data[TIMER_W-1:0];
        REG_COND_MASK:    cfg.condition_enable_mask <= cfg_ch.data[NCOND-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: result register in front of the sink, so a new beat enters
  // whenever the held result leaves in the same cycle.
  // --------------------------------------------------------------------------
  logic      out_valid;
  out_beat_t out_data;
  logic      accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Monitor state
  // --------------------------------------------------------------------------
  logic              out_enabled, out_enabled_next;
  logic              monitor_on, monitor_on_next;
  logic              cause_present, cause_present_next;
  logic [COND_W-1:0] cause_reg, cause_reg_next;
  logic [COND_W-1:0] last_trip, last_trip_next;
  logic [1:0]        relay;

  logic              is_eval, is_tick, is_cmd;
  logic              trip;
  cell_ctrl_t        ctrl;

  assign is_eval = accept && (in_ch.data.req_type == REQ_EVAL) && monitor_on;
  assign is_tick = accept && (in_ch.data.req_type == REQ_TICK);
  assign is_cmd  = accept && ((in_ch.data.req_type == REQ_ENABLE) ||
                              (in_ch.data.req_type == REQ_DISABLE));

  // --------------------------------------------------------------------------
  // Condition compare and timer cell chain. The chain carries "a lower id
  // already expired" from cell 0 upward; its tail is the error flag.
  // --------------------------------------------------------------------------
  logic [NCOND-1:0] fail;
  logic [NCOND:0]   hit;
  logic [NCOND-1:0] first;
  logic             err;

  bfpm_cond u_cond (
    .beat        (in_ch.data),
    .cfg         (cfg),
    .out_enabled (out_enabled),
    .fail        (fail)
  );

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < NCOND; i++) begin : g_cell
    bfpm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .fail    (fail[i]),
      .timeout ((i < 2 * CELL_GROUP) ? cfg.cell_timeout_ms : cfg.pack_timeout_ms),
      .hit_in  (hit[i]),
      .hit_out (hit[i+1]),
      .first   (first[i])
    );
  end

  assign err  = is_eval && hit[NCOND];
  assign trip = err && out_enabled;

  // trip reloads all timers just like enable / disable
  assign ctrl.eval   = is_eval;
  assign ctrl.tick   = is_tick;
  assign ctrl.reload = is_cmd || trip;

  // lowest expired id (first[] is one-hot or empty)
  logic [COND_W-1:0] pick;
  always_comb begin
    pick = '0;
    for (int i = 0; i < NCOND; i++) begin
      if (first[i]) pick = pick | COND_W'(i);
    end
  end

  // does the latched cause still fail? ids past the list count as ok
  logic [(1 << COND_W)-1:0] fail_ext;
  logic                     cause_held;

  assign fail_ext   = {{((1 << COND_W) - NCOND){1'b0}}, fail};
  assign cause_held = cause_present && fail_ext[cause_reg];

  always_comb begin
    out_enabled_next   = out_enabled;
    monitor_on_next    = monitor_on;
    cause_present_next = cause_present;
    cause_reg_next     = cause_reg;
    last_trip_next     = last_trip;
    relay              = RELAY_NONE;
    if (is_eval) begin
      cause_present_next = cause_held;
      if (!cause_held && err) begin
        cause_present_next = 1'b1;
        cause_reg_next     = pick;
      end
      if (trip) begin
        last_trip_next   = cause_held ? cause_reg : pick;
        out_enabled_next = 1'b0;
        relay            = RELAY_DISABLE;
      end
    end else if (is_cmd) begin
      out_enabled_next = (in_ch.data.req_type == REQ_ENABLE);
      monitor_on_next  = 1'b1;
      relay = (in_ch.data.req_type == REQ_ENABLE) ? RELAY_ENABLE : RELAY_DISABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_enabled   <= 1'b0;
      monitor_on    <= 1'b0;
      cause_present <= 1'b0;
      cause_reg     <= '0;
      last_trip     <= '0;
    end else begin
      out_enabled   <= out_enabled_next;
      monitor_on    <= monitor_on_next;
      cause_present <= cause_present_next;
      cause_reg     <= cause_reg_next;
      last_trip     <= last_trip_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.error_active   <= err;
      out_data.output_enabled <= out_enabled_next;
      out_data.cause_valid    <= cause_present_next;
      out_data.cause_id       <= cause_present_next ? cause_reg_next : '0;
      out_data.trip_cause     <= last_trip_next;
      out_data.relay_event    <= relay;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_trip_result: assert property (@(posedge clk) disable iff (rst)
    trip |=> out_ch.valid && !out_ch.data.output_enabled &&
             out_ch.data.relay_event == RELAY_DISABLE && !out_enabled)
    else $error("trip did not disable the output");

  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one cell claims lowest expired");

  a_cause_range: assert property (@(posedge clk) disable iff (rst)
    cause_present |-> cause_reg < COND_W'(NCOND))
    else $error("latched cause out of range");

  a_off_no_error: assert property (@(posedge clk) disable iff (rst)
    (accept && !monitor_on) |=> !out_ch.data.error_active)
    else $error("error reported while monitor is off");

endmodule
